### design/nfc_pkg.sv
`timescale 1ns / 1ps
package nfc_pkg;

  localparam int STORE_BYTES = 2097152;
  localparam int HALF_DEPTH = STORE_BYTES / 2;
  localparam int AW = $clog2(HALF_DEPTH);

  localparam logic [2:0] K_READ_BYTE = 3'd0;
  localparam logic [2:0] K_READ_HALF = 3'd1;
  localparam logic [2:0] K_READ_WORD = 3'd2;
  localparam logic [2:0] K_WRITE_HALF = 3'd3;
  localparam logic [2:0] K_WRITE_WORD = 3'd4;

  localparam logic [1:0] MODE_ARRAY = 2'd0;
  localparam logic [1:0] MODE_AUTOSEL = 2'd1;
  localparam logic [1:0] MODE_CFI = 2'd2;

  localparam logic [10:0] W_UNLOCK1 = 11'h555;
  localparam logic [10:0] W_UNLOCK2 = 11'h2AA;

  localparam logic [7:0] C_RESET = 8'hF0;
  localparam logic [7:0] C_AUTOSEL = 8'h90;
  localparam logic [7:0] C_CFI = 8'h98;
  localparam logic [7:0] C_PROGRAM = 8'hA0;
  localparam logic [7:0] C_ERASE = 8'h80;
  localparam logic [7:0] C_SECTOR = 8'h30;
  localparam logic [7:0] C_CHIP = 8'h10;
  localparam logic [7:0] C_UNLOCK1 = 8'hAA;
  localparam logic [7:0] C_UNLOCK2 = 8'h55;

  localparam int QMAIN_N = 45;
  localparam int QEXT_N = 17;
  localparam logic [7:0] QMAIN [QMAIN_N] = '{
    8'h51, 8'h52, 8'h59, 8'h02, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h27, 8'h36, 8'h00, 8'h00, 8'h03, 8'h00, 8'h09, 8'h00, 8'h05, 8'h00, 8'h04,
    8'h00, 8'h15, 8'h02, 8'h00, 8'h00, 8'h00, 8'h04,
    8'h00, 8'h00, 8'h40, 8'h00, 8'h01, 8'h00, 8'h20, 8'h00,
    8'h00, 8'h00, 8'h80, 8'h00, 8'h1E, 8'h00, 8'h00, 8'h01
  };
  localparam logic [7:0] QEXT [QEXT_N] = '{
    8'h50, 8'h52, 8'h49, 8'h31, 8'h33, 8'h0C, 8'h02, 8'h01, 8'h01, 8'h04,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [20:0] address;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        sequence_error;
    logic [1:0]  read_mode;
  } rsp_t;

  function automatic logic [15:0] id_space(input logic [1:0] mode, input logic [19:0] w);
    logic [15:0] v;
    logic [19:0] d;
    v = 16'hFFFF;
    if (mode == MODE_AUTOSEL) begin
      case (w[7:0])
        8'h00: v = 16'h0001;
        8'h01: v = 16'h227E;
        8'h02: v = 16'h0000;
        8'h03: v = 16'h0014;
        8'h0E: v = 16'h2231;
        8'h0F: v = 16'h2200;
        default: v = 16'hFFFF;
      endcase
    end else if (w >= 20'h10 && w < 20'h10 + 20'(QMAIN_N)) begin
      d = w - 20'h10;
      v = {8'h00, QMAIN[d[5:0]]};
    end else if (w >= 20'h40 && w < 20'h40 + 20'(QEXT_N)) begin
      d = w - 20'h40;
      v = {8'h00, QEXT[d[4:0]]};
    end
    return v;
  endfunction

endpackage

### design/nfc_ram.sv
`timescale 1ns / 1ps
module nfc_ram #(
  parameter int DEPTH = 1024,
  parameter int ABITS = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [ABITS-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### design/nor_flash_command_machine.sv
`timescale 1ns / 1ps
// NOR flash model with a 16-bit command interface, stored as two byte-wide banks (even and
// odd bytes) so that any half access is one read of each bank. After reset the block sweeps
// both banks to 0xFF, one index a cycle, with req_ready low. Reads and command writes go
// from S_IDLE to S_DONE (array reads via S_READ, programs via S_PROG, after the registered
// bank read); no new request is taken until S_DONE hands out the response. A sector erase
// sweeps its size/2 indices and a chip erase all STORE_BYTES/2, one index of both banks per cycle.
module nor_flash_command_machine (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  nfc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output nfc_pkg::rsp_t rsp
);
  import nfc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_PROG  = 5'b00100,
    S_ERASE = 5'b01000,
    S_DONE  = 5'b10000
  } fsm_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_UNL1   = 7'b0000010,
    ST_UNL2   = 7'b0000100,
    ST_PROG   = 7'b0001000,
    ST_ERUNL1 = 7'b0010000,
    ST_ERUNL2 = 7'b0100000,
    ST_ERCONF = 7'b1000000
  } stage_t;

  fsm_t state;
  stage_t stage, stage_next;
  logic [1:0] mode, mode_next;
  rsp_t res;
  logic clearing;
  logic [AW-1:0] ptr, erase_end;
  logic [AW-1:0] e_idx, o_idx;
  logic odd_off, past, is_byte, is_word;
  logic [7:0] prog_val;

  logic accept;
  logic [20:0] off;
  logic [10:0] w;
  logic [7:0] cmd;
  logic is_read, err, do_prog, do_full, do_sect;
  logic [21:0] base, size, top;
  logic [21:0] e_full;
  logic [15:0] idv;

  logic e_we, o_we, ram_re;
  logic [AW-1:0] e_wa, o_wa;
  logic [7:0] e_wd, o_wd, e_q, o_q;
  logic [7:0] lo, hi;

  assign req_ready = (state == S_IDLE);
  assign accept = req_valid && req_ready;
  assign is_read = (req.kind == K_READ_BYTE) || (req.kind == K_READ_HALF)
                || (req.kind == K_READ_WORD);

  always_comb begin
    off = req.address;
    if (req.kind == K_WRITE_WORD) off = {1'b0, req.address[20:1]};
    else if (req.kind == K_READ_WORD) off = {1'b0, req.address[20:2], 1'b0};
    w = off[11:1];
    cmd = req.write_data[7:0];
    e_full = ({1'b0, off} + {21'd0, off[0]}) >> 1;
    idv = id_space(mode, (req.kind == K_READ_WORD) ? {1'b0, req.address[20:2]}
                                                    : req.address[20:1]);
    stage_next = stage;
    mode_next = mode;
    err = 1'b0;
    do_prog = 1'b0;
    do_full = 1'b0;
    do_sect = 1'b0;
    if (off < 21'h4000) begin
      base = 22'h0; size = 22'h4000;
    end else if (off < 21'h6000) begin
      base = 22'h4000; size = 22'h2000;
    end else if (off < 21'h8000) begin
      base = 22'h6000; size = 22'h2000;
    end else if (off < 21'h10000) begin
      base = 22'h8000; size = 22'h8000;
    end else begin
      base = {1'b0, off[20:16], 16'h0}; size = 22'h10000;
    end
    top = base + size;
    if (cmd == C_RESET) begin
      stage_next = ST_IDLE;
      mode_next = MODE_ARRAY;
    end else begin
      case (stage)
        ST_IDLE: begin
          if (cmd == C_CFI) mode_next = MODE_CFI;
          else if (w == W_UNLOCK1 && cmd == C_UNLOCK1) stage_next = ST_UNL1;
          else err = 1'b1;
        end
        ST_UNL1, ST_ERUNL2: begin
          if (w == W_UNLOCK2 && cmd == C_UNLOCK2)
            stage_next = (stage == ST_UNL1) ? ST_UNL2 : ST_ERCONF;
          else err = 1'b1;
        end
        ST_ERUNL1: begin
          if (w == W_UNLOCK1 && cmd == C_UNLOCK1) stage_next = ST_ERUNL2;
          else err = 1'b1;
        end
        ST_UNL2: begin
          if (w != W_UNLOCK1) err = 1'b1;
          else if (cmd == C_AUTOSEL) begin
            mode_next = MODE_AUTOSEL; stage_next = ST_IDLE;
          end else if (cmd == C_CFI) begin
            mode_next = MODE_CFI; stage_next = ST_IDLE;
          end else if (cmd == C_PROGRAM) stage_next = ST_PROG;
          else if (cmd == C_ERASE) stage_next = ST_ERUNL1;
          else err = 1'b1;
        end
        ST_PROG: begin
          do_prog = ({1'b0, off} + 22'd1) < 22'(STORE_BYTES);
          stage_next = ST_IDLE;
          mode_next = MODE_ARRAY;
        end
        ST_ERCONF: begin
          if (w == W_UNLOCK1 && cmd == C_CHIP) do_full = 1'b1;
          else if (cmd == C_SECTOR) do_sect = (top <= 22'(STORE_BYTES));
          else err = 1'b1;
          if (!err) begin
            stage_next = ST_IDLE;
            mode_next = MODE_ARRAY;
          end
        end
        default: err = 1'b1;
      endcase
    end
    if (!(req.kind == K_WRITE_HALF || req.kind == K_WRITE_WORD)) begin
      err = !is_read;
      stage_next = stage;
      mode_next = mode;
      do_prog = 1'b0;
      do_full = 1'b0;
      do_sect = 1'b0;
    end
  end

  // past-end bytes read as erased
  always_comb begin
    lo = odd_off ? o_q : e_q;
    hi = odd_off ? e_q : o_q;
    if (past) begin
      lo = 8'hFF;
      hi = 8'hFF;
    end
  end

  always_comb begin
    ram_re = accept;
    e_we = 1'b0;
    o_we = 1'b0;
    e_wa = e_idx;
    o_wa = o_idx;
    e_wd = 8'hFF;
    o_wd = 8'hFF;
    if (state == S_ERASE) begin
      e_we = 1'b1;
      o_we = 1'b1;
      e_wa = ptr;
      o_wa = ptr;
    end else if (state == S_PROG) begin
      e_we = 1'b1;
      o_we = 1'b1;
      e_wd = odd_off ? 8'h00 : (e_q & prog_val);
      o_wd = odd_off ? (o_q & prog_val) : 8'h00;
    end
  end

  nfc_ram #(.DEPTH(HALF_DEPTH), .ABITS(AW)) u_even (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd),
    .re(ram_re), .raddr(e_full[AW-1:0]), .rdata(e_q)
  );

  nfc_ram #(.DEPTH(HALF_DEPTH), .ABITS(AW)) u_odd (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd),
    .re(ram_re), .raddr(off[AW:1]), .rdata(o_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ERASE;
      stage <= ST_IDLE;
      mode <= MODE_ARRAY;
      clearing <= 1'b1;
      ptr <= '0;
      erase_end <= AW'(HALF_DEPTH - 1);
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            e_idx <= e_full[AW-1:0];
            o_idx <= off[AW:1];
            odd_off <= off[0];
            prog_val <= cmd;
            is_byte <= (req.kind == K_READ_BYTE);
            is_word <= (req.kind == K_READ_WORD);
            past <= (req.kind == K_READ_BYTE) ? ({1'b0, off} >= 22'(STORE_BYTES))
                                              : (({1'b0, off} + 22'd1) >= 22'(STORE_BYTES));
            if (!is_read || mode == MODE_ARRAY) res.read_data <= '0;
            res.sequence_error <= err;
            res.read_mode <= is_read ? mode : mode_next;
            stage <= stage_next;
            mode <= mode_next;
            if (is_read) begin
              if (mode == MODE_ARRAY) state <= S_READ;
              else begin
                state <= S_DONE;
                case (req.kind)
                  K_READ_BYTE: res.read_data <= {24'd0,
                                 req.address[0] ? idv[15:8] : idv[7:0]};
                  K_READ_HALF: res.read_data <= {16'd0, idv};
                  default:     res.read_data <= {4{idv[7:0]}};
                endcase
              end
            end else if (do_prog) state <= S_PROG;
            else if (do_full) begin
              ptr <= '0;
              erase_end <= AW'(HALF_DEPTH - 1);
              state <= S_ERASE;
            end else if (do_sect) begin
              ptr <= base[AW:1];
              erase_end <= AW'((top >> 1) - 22'd1);
              state <= S_ERASE;
            end else state <= S_DONE;
          end
        end
        S_READ: begin
          if (is_byte) res.read_data <= {24'd0, lo};
          else if (is_word) res.read_data <= {4{lo}};
          else res.read_data <= {16'd0, hi, lo};
          state <= S_DONE;
        end
        S_PROG: state <= S_DONE;
        S_ERASE: begin
          if (ptr == erase_end) begin
            clearing <= 1'b0;
            state <= clearing ? S_IDLE : S_DONE;
          end else ptr <= ptr + AW'(1);
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp <= res;
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req_ready) else $error("request taken while busy");
  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_ERASE) |-> !req_ready && (ptr <= erase_end))
    else $error("erase sweep out of range or not blocking");
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    (state == S_ERASE && clearing) |=> !$rose(rsp_valid))
    else $error("response produced by the reset sweep");

endmodule
